// ===== rtl/core/rsi_pkg.sv =====
package rsi_pkg;

   // Field widths of the request and response beats.
   localparam int CoordW = 16;
   localparam int RadW   = 15;
   localparam int DistW  = 24;

   // Internal widths that follow from the coordinate width.
   // The difference origin - center needs one bit more than a coordinate.
   localparam int DiffW  = CoordW + 1;
   // Half of b: three products of a difference and a direction component.
   localparam int HW     = 34;
   // Constant term: three squared differences less the squared radius.
   localparam int CW     = 35;
   // Squared direction length.
   localparam int AW     = 32;
   // Magnitudes of the half-b and constant terms.
   localparam int MagW   = 33;
   localparam int CMagW  = 34;
   // Full products of the discriminant terms.
   localparam int ProdW  = 66;
   // Low half of a split multiplier operand.
   localparam int SplitW = 17;
   // Discriminant as seen by the square root: a whole number of bit pairs.
   localparam int QPairs = 35;
   localparam int QW     = 2 * QPairs;

   // Control bits that travel with each beat down the pipeline.
   typedef struct packed {
      logic valid;
      logic live;   // Still a candidate hit.
      logic near;   // Use the nearer root.
      logic hneg;   // Half of b is negative.
   } rsi_ctl_type;

   // One response beat.
   typedef struct packed {
      logic             hit;
      logic [DistW-1:0] distance;
      logic             saturated;
   } rsi_res_type;

endpackage

// ===== rtl/core/rsi_front.sv =====
module rsi_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [rsi_pkg::CoordW-1:0]   origin_x,
   input  logic signed [rsi_pkg::CoordW-1:0]   origin_y,
   input  logic signed [rsi_pkg::CoordW-1:0]   origin_z,
   input  logic signed [rsi_pkg::CoordW-1:0]   direction_x,
   input  logic signed [rsi_pkg::CoordW-1:0]   direction_y,
   input  logic signed [rsi_pkg::CoordW-1:0]   direction_z,
   input  logic signed [rsi_pkg::CoordW-1:0]   center_x,
   input  logic signed [rsi_pkg::CoordW-1:0]   center_y,
   input  logic signed [rsi_pkg::CoordW-1:0]   center_z,
   input  logic        [rsi_pkg::RadW-1:0]     radius,
   output rsi_pkg::rsi_ctl_type                ctl_out,
   output logic        [rsi_pkg::QW-1:0]       q_out,
   output logic        [rsi_pkg::MagW-1:0]     mag_out,
   output logic        [rsi_pkg::AW-1:0]       a_out
);
   import rsi_pkg::*;

   logic signed [CoordW-1:0] o_v [3];
   logic signed [CoordW-1:0] c_v [3];
   logic signed [CoordW-1:0] d_v [3];

   // Stage 1: differences.
   logic                      v1_ff;
   logic signed [DiffW-1:0]   w_ff [3];
   logic signed [CoordW-1:0]  d_ff [3];
   logic        [RadW-1:0]    r_ff;

   // Stage 2: products.
   logic                          v2_ff;
   logic signed [DiffW+CoordW-1:0] hd_in [3];
   logic signed [DiffW+CoordW-1:0] hd_ff [3];
   logic signed [2*DiffW-1:0]      ww_in [3];
   logic signed [2*DiffW-1:0]      ww_ff [3];
   logic signed [2*CoordW-1:0]     dd_in [3];
   logic signed [2*CoordW-1:0]     dd_ff [3];
   logic        [2*RadW-1:0]       rr_ff;

   // Stage 3: sums.
   logic                 v3_ff;
   logic signed [HW-1:0] h_ff;
   logic signed [CW-1:0] c_ff;
   logic        [AW-1:0] a3_ff;

   // Stage 4: magnitudes and case flags.
   logic signed [HW-1:0] h_neg;
   logic signed [CW-1:0] c_neg;
   rsi_ctl_type          ctl4_in;
   rsi_ctl_type          ctl4_ff;
   logic                 cpos4_ff;
   logic [MagW-1:0]      mag4_ff;
   logic [CMagW-1:0]     cmag4_ff;
   logic [AW-1:0]        a4_ff;

   // Stage 5: split partial products.
   rsi_ctl_type                ctl5_ff;
   logic                       cpos5_ff;
   logic [MagW+SplitW-1:0]     hhl_ff;
   logic [2*MagW-SplitW-1:0]   hhh_ff;
   logic [AW+SplitW-1:0]       acl_ff;
   logic [AW+CMagW-SplitW-1:0] ach_ff;
   logic [MagW-1:0]            mag5_ff;
   logic [AW-1:0]              a5_ff;

   // Stage 6: full products.
   rsi_ctl_type     ctl6_ff;
   logic            cpos6_ff;
   logic [ProdW-1:0] hh_ff;
   logic [ProdW-1:0] ac_ff;
   logic [MagW-1:0]  mag6_ff;
   logic [AW-1:0]    a6_ff;

   // Stage 7: discriminant.
   rsi_ctl_type     ctl7_in;
   rsi_ctl_type     ctl7_ff;
   logic [QW-1:0]   q_in;
   logic [QW-1:0]   q_ff;
   logic [MagW-1:0] mag7_ff;
   logic [AW-1:0]   a7_ff;

   assign o_v[0] = origin_x;
   assign o_v[1] = origin_y;
   assign o_v[2] = origin_z;
   assign c_v[0] = center_x;
   assign c_v[1] = center_y;
   assign c_v[2] = center_z;
   assign d_v[0] = direction_x;
   assign d_v[1] = direction_y;
   assign d_v[2] = direction_z;

   // Valid bits for stages 1 to 3; later stages carry valid in the control word.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage 1 registers the ray origin relative to the sphere center.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            w_ff[k] <= DiffW'(o_v[k]) - DiffW'(c_v[k]);
            d_ff[k] <= d_v[k];
         end
         r_ff <= radius;
      end
   end

   // Stage 2 forms every dot-product term in parallel.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hd_in[k] = w_ff[k] * d_ff[k];
         ww_in[k] = w_ff[k] * w_ff[k];
         dd_in[k] = d_ff[k] * d_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hd_ff <= hd_in;
         ww_ff <= ww_in;
         dd_ff <= dd_in;
         rr_ff <= r_ff * r_ff;
      end
   end

   // Stage 3 sums the terms into half of b, the constant term and a.
   always_ff @(posedge clock) begin
      if (en) begin
         h_ff  <= HW'(hd_ff[0]) + HW'(hd_ff[1]) + HW'(hd_ff[2]);
         c_ff  <= CW'(ww_ff[0]) + CW'(ww_ff[1]) + CW'(ww_ff[2])
                  - CW'($signed({1'b0, rr_ff}));
         a3_ff <= AW'($unsigned(dd_ff[0])) + AW'($unsigned(dd_ff[1]))
                  + AW'($unsigned(dd_ff[2]));
      end
   end

   // Stage 4 decides which root applies and drops rays that cannot hit.
   assign h_neg = -h_ff;
   assign c_neg = -c_ff;

   always_comb begin
      ctl4_in.valid = v3_ff;
      ctl4_in.live  = (a3_ff != '0) && (h_ff[HW-1] || c_ff[CW-1]);
      ctl4_in.near  = h_ff[HW-1] && !c_ff[CW-1] && (c_ff != '0);
      ctl4_in.hneg  = h_ff[HW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else if (en) begin
         ctl4_ff <= ctl4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cpos4_ff <= !c_ff[CW-1] && (c_ff != '0);
         mag4_ff  <= h_ff[HW-1] ? MagW'(h_neg) : MagW'(h_ff);
         cmag4_ff <= c_ff[CW-1] ? CMagW'(c_neg) : CMagW'(c_ff);
         a4_ff    <= a3_ff;
      end
   end

   // Stage 5 multiplies |h| by its own two halves and a by the two halves of |c|.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff <= '0;
      end else if (en) begin
         ctl5_ff <= ctl4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cpos5_ff <= cpos4_ff;
         hhl_ff   <= mag4_ff * mag4_ff[SplitW-1:0];
         hhh_ff   <= mag4_ff * mag4_ff[MagW-1:SplitW];
         acl_ff   <= a4_ff * cmag4_ff[SplitW-1:0];
         ach_ff   <= a4_ff * cmag4_ff[CMagW-1:SplitW];
         mag5_ff  <= mag4_ff;
         a5_ff    <= a4_ff;
      end
   end

   // Stage 6 adds the partial products.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl6_ff <= '0;
      end else if (en) begin
         ctl6_ff <= ctl5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cpos6_ff <= cpos5_ff;
         hh_ff    <= ProdW'(hhl_ff) + (ProdW'(hhh_ff) << SplitW);
         ac_ff    <= ProdW'(acl_ff) + (ProdW'(ach_ff) << SplitW);
         mag6_ff  <= mag5_ff;
         a6_ff    <= a5_ff;
      end
   end

   // Stage 7 forms the quarter discriminant; a negative one is a miss.
   always_comb begin
      ctl7_in = ctl6_ff;
      if (cpos6_ff) begin
         q_in = QW'(hh_ff) - QW'(ac_ff);
         if (hh_ff < ac_ff) begin
            ctl7_in.live = 1'b0;
         end
      end else begin
         q_in = QW'(hh_ff) + QW'(ac_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl7_ff <= '0;
      end else if (en) begin
         ctl7_ff <= ctl7_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff    <= q_in;
         mag7_ff <= mag6_ff;
         a7_ff   <= a6_ff;
      end
   end

   assign ctl_out = ctl7_ff;
   assign q_out   = q_ff;
   assign mag_out = mag7_ff;
   assign a_out   = a7_ff;

endmodule

// ===== rtl/core/rsi_sqrt.sv =====
module rsi_sqrt #(
   parameter int DIST_FRAC_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         en,
   input  rsi_pkg::rsi_ctl_type                         ctl_in,
   input  logic [rsi_pkg::QW-1:0]                       q_in,
   input  logic [rsi_pkg::MagW-1:0]                     mag_in,
   input  logic [rsi_pkg::AW-1:0]                       a_in,
   output rsi_pkg::rsi_ctl_type                         ctl_out,
   output logic [rsi_pkg::QPairs+DIST_FRAC_BITS-1:0]    root_out,
   output logic [rsi_pkg::MagW-1:0]                     mag_out,
   output logic [rsi_pkg::AW-1:0]                       a_out
);
   import rsi_pkg::*;

   // One root bit per stage; the radicand is the discriminant followed by
   // DIST_FRAC_BITS zero bit pairs.
   localparam int Rb   = QPairs + DIST_FRAC_BITS;
   localparam int RemW = Rb + 2;

   rsi_ctl_type     ctl_ff  [Rb];
   logic [Rb-1:0]   root_ff [Rb];
   logic [MagW-1:0] mag_ff  [Rb];
   logic [AW-1:0]   a_ff    [Rb];
   logic [RemW-1:0] rem_ff  [Rb-1];
   logic [QW-1:0]   q_ff    [Rb-1];

   for (genvar i = 0; i < Rb; i++) begin : g_step
      rsi_ctl_type     ctl_prev;
      logic [Rb-1:0]   root_prev;
      logic [RemW-1:0] rem_prev;
      logic [QW-1:0]   q_prev;
      logic [MagW-1:0] mag_prev;
      logic [AW-1:0]   a_prev;
      logic [RemW-1:0] rem_sh;
      logic [RemW-1:0] trial;
      logic            take;

      if (i == 0) begin : g_first
         assign ctl_prev  = ctl_in;
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign q_prev    = q_in;
         assign mag_prev  = mag_in;
         assign a_prev    = a_in;
      end else begin : g_next
         assign ctl_prev  = ctl_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign q_prev    = q_ff[i-1];
         assign mag_prev  = mag_ff[i-1];
         assign a_prev    = a_ff[i-1];
      end

      // Bring down the next bit pair and try to set the next root bit.
      assign rem_sh = {rem_prev[Rb-1:0], q_prev[QW-1 -: 2]};
      assign trial  = {root_prev, 2'b01};
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (en) begin
            ctl_ff[i] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[i] <= {root_prev[Rb-2:0], take};
            mag_ff[i]  <= mag_prev;
            a_ff[i]    <= a_prev;
         end
      end

      // The last step needs no remainder and no radicand after it.
      if (i < Rb - 1) begin : g_rem
         logic [RemW-1:0] rem_in;

         assign rem_in = take ? (rem_sh - trial) : rem_sh;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= rem_in;
               q_ff[i]   <= {q_prev[QW-3:0], 2'b00};
            end
         end
      end
   end

   assign ctl_out  = ctl_ff[Rb-1];
   assign root_out = root_ff[Rb-1];
   assign mag_out  = mag_ff[Rb-1];
   assign a_out    = a_ff[Rb-1];

endmodule

// ===== rtl/core/rsi_div.sv =====
module rsi_div #(
   parameter int DIST_FRAC_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         en,
   input  rsi_pkg::rsi_ctl_type                         ctl_in,
   input  logic [rsi_pkg::QPairs+DIST_FRAC_BITS-1:0]    root_in,
   input  logic [rsi_pkg::MagW-1:0]                     mag_in,
   input  logic [rsi_pkg::AW-1:0]                       a_in,
   output rsi_pkg::rsi_ctl_type                         ctl_out,
   output logic                                         sat_out,
   output logic [rsi_pkg::DistW-1:0]                    quo_out
);
   import rsi_pkg::*;

   localparam int Rb   = QPairs + DIST_FRAC_BITS;
   localparam int NumW = Rb + 1;
   localparam int LimW = AW + DistW;
   localparam int XW   = (NumW > LimW) ? NumW : LimW;

   // Numerator stage.
   rsi_ctl_type   ctln_ff;
   logic [XW-1:0] scale_h;
   logic [XW-1:0] root_x;
   logic [XW-1:0] num_in;
   logic [XW-1:0] num_ff;
   logic [AW-1:0] an_ff;

   // Saturation stage.
   rsi_ctl_type   ctls_ff;
   logic          sats_ff;
   logic [XW-1:0] rems_ff;
   logic [AW-1:0] as_ff;

   // Quotient stages, one bit each, most significant first.
   rsi_ctl_type      ctl_ff [DistW];
   logic             sat_ff [DistW];
   logic [DistW-1:0] quo_ff [DistW];
   logic [XW-1:0]    rem_ff [DistW-1];
   logic [AW-1:0]    a_ff   [DistW-1];

   // Pick the root that is the nearest positive one.
   assign scale_h = XW'(mag_in) << DIST_FRAC_BITS;
   assign root_x  = XW'(root_in);

   always_comb begin
      if (ctl_in.near) begin
         num_in = scale_h - root_x;
      end else if (ctl_in.hneg) begin
         num_in = scale_h + root_x;
      end else begin
         num_in = root_x - scale_h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctln_ff <= '0;
         ctls_ff <= '0;
      end else if (en) begin
         ctln_ff <= ctl_in;
         ctls_ff <= ctln_ff;
      end
   end

   // A quotient of 2^DistW or more clips.
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         an_ff   <= a_in;
         sats_ff <= (num_ff >= (XW'(an_ff) << DistW));
         rems_ff <= num_ff;
         as_ff   <= an_ff;
      end
   end

   for (genvar j = 0; j < DistW; j++) begin : g_bit
      rsi_ctl_type      ctl_prev;
      logic             sat_prev;
      logic [DistW-1:0] quo_prev;
      logic [XW-1:0]    rem_prev;
      logic [AW-1:0]    a_prev;
      logic [XW-1:0]    dvs;
      logic             take;

      if (j == 0) begin : g_first
         assign ctl_prev = ctls_ff;
         assign sat_prev = sats_ff;
         assign quo_prev = '0;
         assign rem_prev = rems_ff;
         assign a_prev   = as_ff;
      end else begin : g_next
         assign ctl_prev = ctl_ff[j-1];
         assign sat_prev = sat_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign a_prev   = a_ff[j-1];
      end

      // Restoring step against the divisor shifted to this bit.
      assign dvs  = XW'(a_prev) << (DistW - 1 - j);
      assign take = (rem_prev >= dvs);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else if (en) begin
            ctl_ff[j] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sat_ff[j] <= sat_prev;
            quo_ff[j] <= {quo_prev[DistW-2:0], take};
         end
      end

      if (j < DistW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= take ? (rem_prev - dvs) : rem_prev;
               a_ff[j]   <= a_prev;
            end
         end
      end
   end

   assign ctl_out = ctl_ff[DistW-1];
   assign sat_out = sat_ff[DistW-1];
   assign quo_out = quo_ff[DistW-1];

endmodule

// ===== rtl/core/ray_sphere_intersect.sv =====
// Ray-sphere intersection, one test per request beat.
// A request beat carries a ray origin, a ray direction, a sphere center and
// a radius, all in signed fixed point with a shared scale. The response beat
// gives the nearest positive intersection distance in unsigned Q8.16 (the
// fraction width is DIST_FRAC_BITS), a hit flag and a saturation flag.
// A zero direction, a ray that misses or a sphere fully behind the ray
// returns a beat with all fields zero.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. Every request beat yields exactly one response beat, in order.
// From request to response valid a beat passes seven setup stages, one
// square-root stage per root bit (35 + DIST_FRAC_BITS), a numerator stage,
// a saturation stage, one divide stage per distance bit and the response
// register. Throughput is one beat per cycle while req_stall is low.
// When the receiver stalls, one more beat is caught in a skid register; the
// pipeline then holds and req_stall rises until the response side drains.
// Reset empties the pipeline, the response register and the skid register.
module ray_sphere_intersect #(
   parameter int DIST_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rsi_pkg::CoordW-1:0]   req_origin_x,
   input  logic signed [rsi_pkg::CoordW-1:0]   req_origin_y,
   input  logic signed [rsi_pkg::CoordW-1:0]   req_origin_z,
   input  logic signed [rsi_pkg::CoordW-1:0]   req_direction_x,
   input  logic signed [rsi_pkg::CoordW-1:0]   req_direction_y,
   input  logic signed [rsi_pkg::CoordW-1:0]   req_direction_z,
   input  logic signed [rsi_pkg::CoordW-1:0]   req_center_x,
   input  logic signed [rsi_pkg::CoordW-1:0]   req_center_y,
   input  logic signed [rsi_pkg::CoordW-1:0]   req_center_z,
   input  logic        [rsi_pkg::RadW-1:0]     req_radius,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic        [rsi_pkg::DistW-1:0]    rsp_distance,
   output logic                                rsp_saturated
);
   import rsi_pkg::*;

   localparam int Rb = QPairs + DIST_FRAC_BITS;

   logic            en;
   logic            take;
   rsi_ctl_type     f_ctl;
   logic [QW-1:0]   f_q;
   logic [MagW-1:0] f_mag;
   logic [AW-1:0]   f_a;
   rsi_ctl_type     s_ctl;
   logic [Rb-1:0]   s_root;
   logic [MagW-1:0] s_mag;
   logic [AW-1:0]   s_a;
   rsi_ctl_type     d_ctl;
   logic            d_sat;
   logic [DistW-1:0] d_quo;
   rsi_res_type     res_new;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsi_res_type     rsp_ff;
   rsi_res_type     rsp_in;
   logic            skid_valid_ff;
   logic            skid_valid_in;
   rsi_res_type     skid_ff;
   rsi_res_type     skid_in;

   // The pipeline moves whenever the skid register is empty.
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   rsi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .origin_x    (req_origin_x),
      .origin_y    (req_origin_y),
      .origin_z    (req_origin_z),
      .direction_x (req_direction_x),
      .direction_y (req_direction_y),
      .direction_z (req_direction_z),
      .center_x    (req_center_x),
      .center_y    (req_center_y),
      .center_z    (req_center_z),
      .radius      (req_radius),
      .ctl_out     (f_ctl),
      .q_out       (f_q),
      .mag_out     (f_mag),
      .a_out       (f_a)
   );

   rsi_sqrt #(
      .DIST_FRAC_BITS (DIST_FRAC_BITS)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (f_ctl),
      .q_in     (f_q),
      .mag_in   (f_mag),
      .a_in     (f_a),
      .ctl_out  (s_ctl),
      .root_out (s_root),
      .mag_out  (s_mag),
      .a_out    (s_a)
   );

   rsi_div #(
      .DIST_FRAC_BITS (DIST_FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (s_ctl),
      .root_in (s_root),
      .mag_in  (s_mag),
      .a_in    (s_a),
      .ctl_out (d_ctl),
      .sat_out (d_sat),
      .quo_out (d_quo)
   );

   // Format the result; a miss clears every field.
   always_comb begin
      res_new.hit       = d_ctl.live;
      res_new.saturated = d_ctl.live && d_sat;
      if (!d_ctl.live) begin
         res_new.distance = '0;
      end else if (d_sat) begin
         res_new.distance = '1;
      end else begin
         res_new.distance = d_quo;
      end
   end

   // Response register with a skid register behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (d_ctl.valid) begin
         if (rsp_valid_ff && !take) begin
            skid_valid_in = 1'b1;
            skid_in       = res_new;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_in       = res_new;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_ff.hit;
   assign rsp_distance  = rsp_ff.distance;
   assign rsp_saturated = rsp_ff.saturated;

   // The skid register only fills behind a waiting response.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a beat with no response pending");

   // A miss carries no distance.
   a_miss_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.hit) |-> (rsp_ff.distance == '0 && !rsp_ff.saturated))
      else $error("miss response carries a distance");

   // A clipped distance is the largest code.
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.saturated) |-> (rsp_ff.hit && rsp_ff.distance == '1))
      else $error("saturated response without the largest distance");

   // A stalled response with an empty skid register parks the next beat.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !skid_valid_ff && d_ctl.valid) |=> skid_valid_ff)
      else $error("beat lost behind a stalled response");

endmodule
